// ===== hw/rtl/swhc_pkg.sv =====
package swhc_pkg;

  localparam int unsigned TimestampW = 32;
  localparam int unsigned WindowW    = 16;
  localparam int unsigned HitCountW  = 11;

  // Action codes carried by an input item.
  localparam logic ActHit   = 1'b0;
  localparam logic ActQuery = 1'b1;

  localparam logic [WindowW-1:0] WindowReset = 16'd300;

  typedef struct packed {
    logic                  action;
    logic [TimestampW-1:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [HitCountW-1:0] hit_count;
    logic                 overflow;
  } out_item_t;

endpackage

// ===== hw/rtl/swhc_ram.sv =====
module swhc_ram #(
  parameter int unsigned DataW = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sliding_window_hit_counter.sv =====
// Channel   Direction  Handshake             Payload
// in        input      in_valid_i/in_stall_o  swhc_pkg::in_item_t (action, timestamp)
// out       output     out_valid_o/out_stall_i swhc_pkg::out_item_t (hit_count, overflow)
// cfg       input      cfg_we_i               cfg_wdata_i (window length, 16 bits)
//
// Expiry spends a read and a compare state on each stamp read (registered ring read, then the
// shared 33-bit add and compare) and stops at a live stamp or when no live stamp is left; the
// finish state then loads the output register. The sequencer takes the next item in the cycle
// after loading a result, even if that result still waits for the sink.
// Reset clears the pointers and the count and loads 300 into the window register.
// A stalled result holds the sequencer in its final state until the output register frees up.
module sliding_window_hit_counter #(
  parameter int unsigned RING_DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  swhc_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output swhc_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [swhc_pkg::WindowW-1:0]  cfg_wdata_i
);

  localparam int unsigned PtrW = $clog2(RING_DEPTH);
  localparam int unsigned CntW = $clog2(RING_DEPTH + 1);
  localparam int unsigned TsW  = swhc_pkg::TimestampW;
  localparam int unsigned HcW  = swhc_pkg::HitCountW;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StCmp,
    StFin
  } state_e;

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    if (p == PtrW'(RING_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PtrW'(1);
    end
    return n;
  endfunction

  state_e                       state_q, state_d;
  logic [PtrW-1:0]              oldest_q, oldest_d;
  logic [PtrW-1:0]              newest_q, newest_d;
  logic [CntW-1:0]              count_q, count_d;
  logic [swhc_pkg::WindowW-1:0] window_q, window_d;
  logic                         action_q, action_d;
  logic [TsW-1:0]               now_q, now_d;
  logic                         out_valid_q, out_valid_d;
  swhc_pkg::out_item_t          out_q, out_d;

  logic            in_fire;
  logic            out_free;
  logic            rd_en;
  logic            wr_en;
  logic [TsW-1:0]  rd_data;
  logic [TsW:0]    stamp_end;
  logic            expired;
  logic            ring_full;
  logic            push;
  logic [CntW-1:0] count_fin;
  logic [CntW+HcW-1:0] count_ext;

  assign in_stall_o = (state_q != StIdle);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign ring_full  = (count_q == CntW'(RING_DEPTH));

  // Shared unit: a stored stamp has expired once stamp + window no longer exceeds now.
  assign stamp_end = {1'b0, rd_data} + {{(TsW + 1 - swhc_pkg::WindowW){1'b0}}, window_q};
  assign expired   = (stamp_end <= {1'b0, now_q});

  assign rd_en     = (state_q == StRead) && (count_q != '0);
  assign push      = (action_q == swhc_pkg::ActHit) && !ring_full;
  assign wr_en     = (state_q == StFin) && out_free && push;
  assign count_fin = count_q + CntW'(push);
  assign count_ext = {{HcW{1'b0}}, count_fin};

  swhc_ram #(
    .DataW(TsW),
    .Depth(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(newest_q),
    .wdata_i(now_q),
    .re_i   (rd_en),
    .raddr_i(oldest_q),
    .rdata_o(rd_data)
  );

  always_comb begin
    state_d     = state_q;
    oldest_d    = oldest_q;
    newest_d    = newest_q;
    count_d     = count_q;
    window_d    = window_q;
    action_d    = action_q;
    now_d       = now_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (cfg_we_i) begin
      window_d = cfg_wdata_i;
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          action_d = in_item_i.action;
          now_d    = in_item_i.timestamp;
          state_d  = StRead;
        end
      end
      StRead: begin
        if (count_q == '0) begin
          state_d = StFin;
        end else begin
          state_d = StCmp;
        end
      end
      StCmp: begin
        if (expired) begin
          oldest_d = next_slot(oldest_q);
          count_d  = count_q - CntW'(1);
          state_d  = StRead;
        end else begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_free) begin
          if (push) begin
            newest_d = next_slot(newest_q);
          end
          count_d             = count_fin;
          out_d.hit_count     = count_ext[HcW-1:0];
          out_d.overflow      = (action_q == swhc_pkg::ActHit) && ring_full;
          out_valid_d         = 1'b1;
          state_d             = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      oldest_q    <= '0;
      newest_q    <= '0;
      count_q     <= '0;
      window_q    <= swhc_pkg::WindowReset;
      action_q    <= swhc_pkg::ActQuery;
      now_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      newest_q    <= newest_d;
      count_q     <= count_d;
      window_q    <= window_d;
      action_q    <= action_d;
      now_q       <= now_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Pointer bookkeeping: the newest slot always sits count entries past the oldest one.
  logic [PtrW:0] ptr_sum;
  logic [PtrW:0] ptr_wrap;
  assign ptr_sum  = {1'b0, oldest_q} + (PtrW + 1)'(count_q);
  assign ptr_wrap = (ptr_sum >= (PtrW + 1)'(RING_DEPTH)) ?
                    ptr_sum - (PtrW + 1)'(RING_DEPTH) : ptr_sum;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(RING_DEPTH))
    else $error("live count exceeds ring depth");

  a_ptr_consistent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_wrap[PtrW-1:0] == newest_q)
    else $error("ring pointers disagree with live count");

  a_count_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle || state_q == StRead) |=> $stable(count_q))
    else $error("live count changed outside compare or finish");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o && !$stable(state_q))
    else $error("sequencer did not start after an accepted item");

  a_overflow_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin && out_free && !push && action_q == swhc_pkg::ActHit)
      |=> out_valid_q && out_q.overflow && $stable(count_q))
    else $error("dropped hit not flagged or count changed");

endmodule

// ===== verif/sliding_window_hit_counter_tb.sv =====
module sliding_window_hit_counter_tb;

  localparam int unsigned RingDepth   = 1024;
  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned DrainCycles = 2 * RingDepth + 64;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned PhaseItems  = 12;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  swhc_pkg::in_item_t            in_item_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  swhc_pkg::out_item_t           out_item_o;
  logic                          cfg_we_i;
  logic [swhc_pkg::WindowW-1:0]  cfg_wdata_i;

  // Shadow state: live hit stamps oldest first, and the window length.
  logic [swhc_pkg::TimestampW-1:0] live_stamps [$];
  logic [swhc_pkg::WindowW-1:0]    window_len;
  swhc_pkg::out_item_t             expected_tallies [$];
  int unsigned                     mismatch_count;
  int unsigned                     send_idle_pct;
  int unsigned                     recv_stall_pct;

  sliding_window_hit_counter #(
    .RING_DEPTH(RingDepth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic swhc_pkg::out_item_t predict_tally(input swhc_pkg::in_item_t item);
    swhc_pkg::out_item_t             res;
    logic [swhc_pkg::TimestampW:0]   stamp_end;
    logic                            expiring;
    int unsigned                     live;
    res.overflow = 1'b0;
    expiring = 1'b1;
    // Expiry stops at the first stamp still inside the window.
    while (expiring && live_stamps.size() != 0) begin
      stamp_end = {1'b0, live_stamps[0]} +
                  {{(swhc_pkg::TimestampW + 1 - swhc_pkg::WindowW){1'b0}}, window_len};
      if (stamp_end <= {1'b0, item.timestamp}) begin
        void'(live_stamps.pop_front());
      end else begin
        expiring = 1'b0;
      end
    end
    if (item.action == swhc_pkg::ActHit) begin
      if (live_stamps.size() >= RingDepth) begin
        res.overflow = 1'b1;
      end else begin
        live_stamps = {live_stamps, item.timestamp};
      end
    end
    live = live_stamps.size();
    res.hit_count = live[swhc_pkg::HitCountW-1:0];
    return res;
  endfunction

  function automatic void set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 73;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 73;
      end
      default: begin
        send_idle_pct  = 15;
        recv_stall_pct = 15;
      end
    endcase
  endfunction

  // Mostly small forward steps, with some repeats, some jumps past the
  // whole window and a few steps back in time.
  function automatic logic [swhc_pkg::TimestampW-1:0] advance_stamp(
    input logic [swhc_pkg::TimestampW-1:0] ts,
    input logic [swhc_pkg::WindowW-1:0]    len
  );
    int unsigned                   roll;
    int unsigned                   step;
    logic [swhc_pkg::TimestampW:0] wide;
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      step = $urandom_range(0, len);
      return (ts > step) ? ts - step : '0;
    end
    if (roll < 10) begin
      step = $urandom_range(len, 2 * len + 8);
    end else if (roll < 30) begin
      step = 0;
    end else begin
      step = $urandom_range(0, len / 8 + 1);
    end
    wide = {1'b0, ts} + {1'b0, step};
    return wide[swhc_pkg::TimestampW] ? '1 : wide[swhc_pkg::TimestampW-1:0];
  endfunction

  // Called and returning at a falling edge.
  task automatic send_item(input logic act, input logic [swhc_pkg::TimestampW-1:0] ts);
    swhc_pkg::in_item_t item;
    item.action    = act;
    item.timestamp = ts;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    expected_tallies = {expected_tallies, predict_tally(item)};
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_tallies.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_window(input logic [swhc_pkg::WindowW-1:0] len);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    window_len = len;
  endtask

  // Window length straight out of reset.
  task automatic test_reset_window();
    set_idling(0);
    send_item(swhc_pkg::ActHit, 32'd0);
    send_item(swhc_pkg::ActQuery, 32'd0);
    send_item(swhc_pkg::ActHit, 32'd299);
    send_item(swhc_pkg::ActQuery, 32'd299);
    send_item(swhc_pkg::ActQuery, 32'd300);
    send_item(swhc_pkg::ActQuery, 32'd598);
    send_item(swhc_pkg::ActQuery, 32'd599);
  endtask

  // Shortest and longest windows, with stamps at the top of the range where
  // the end of the window no longer fits in 32 bits.
  task automatic test_window_extremes();
    set_idling(3);
    write_window(16'd1);
    send_item(swhc_pkg::ActHit, 32'd10);
    send_item(swhc_pkg::ActQuery, 32'd10);
    send_item(swhc_pkg::ActQuery, 32'd11);
    write_window(16'hFFFF);
    send_item(swhc_pkg::ActHit, 32'hFFFF_0000);
    send_item(swhc_pkg::ActHit, 32'hFFFF_FFFF);
    send_item(swhc_pkg::ActQuery, 32'hFFFF_FFFF);
    write_window(16'd0);
    send_item(swhc_pkg::ActQuery, 32'hFFFF_FFFF);
  endtask

  // With a zero window every older stamp expires, but a fresh hit still counts.
  task automatic test_window_zero();
    set_idling(2);
    send_item(swhc_pkg::ActHit, 32'd5);
    send_item(swhc_pkg::ActHit, 32'd5);
    send_item(swhc_pkg::ActQuery, 32'd5);
  endtask

  task automatic test_decreasing_time();
    set_idling(1);
    write_window(16'd100);
    send_item(swhc_pkg::ActHit, 32'd1000);
    send_item(swhc_pkg::ActHit, 32'd500);
    send_item(swhc_pkg::ActQuery, 32'd1099);
    send_item(swhc_pkg::ActQuery, 32'd1100);
    send_item(swhc_pkg::ActHit, 32'd0);
  endtask

  task automatic test_ring_full();
    logic [swhc_pkg::TimestampW-1:0] ts;
    set_idling(3);
    write_window(16'hFFFF);
    ts = $urandom_range(0, 32'h7FFF_FFFF);
    while (live_stamps.size() < RingDepth) begin
      ts = ts + 32'($urandom_range(0, 1));
      send_item(swhc_pkg::ActHit, ts);
    end
    repeat (4) send_item(swhc_pkg::ActHit, ts);
    send_item(swhc_pkg::ActQuery, ts);
    // One item that walks the whole ring.
    send_item(swhc_pkg::ActQuery, ts + 32'hFFFF);
  endtask

  task automatic test_random_traffic();
    logic [swhc_pkg::WindowW-1:0]    len;
    logic [swhc_pkg::TimestampW-1:0] ts;
    logic                            act;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: len = 16'd1;
        1: len = 16'hFFFF;
        2: len = swhc_pkg::WindowReset;
        3: len = swhc_pkg::WindowW'($urandom_range(2, 64));
        4: len = 16'd16;
        default: len = swhc_pkg::WindowW'($urandom_range(1, 16'hFFFF));
      endcase
      write_window(len);
      set_idling(phase % 4);
      ts = $urandom();
      repeat (PhaseItems) begin
        ts  = advance_stamp(ts, len);
        act = ($urandom_range(0, 99) < 70) ? swhc_pkg::ActHit : swhc_pkg::ActQuery;
        send_item(act, ts);
      end
    end
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_tallies
    swhc_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_tallies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("unexpected result: hit_count=%0d overflow=%0b",
                   out_item_o.hit_count, out_item_o.overflow);
        end
      end else begin
        want = expected_tallies.pop_front();
        if (out_item_o.hit_count !== want.hit_count ||
            out_item_o.overflow !== want.overflow) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("tally mismatch: expected count=%0d ovf=%0b, got count=%0d ovf=%0b",
                     want.hit_count, want.overflow,
                     out_item_o.hit_count, out_item_o.overflow);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    window_len     = swhc_pkg::WindowReset;
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_window();
    test_window_extremes();
    test_window_zero();
    test_decreasing_time();
    test_ring_full();
    test_random_traffic();

    wait_idle();
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/swhc_pkg.sv
hw/rtl/swhc_ram.sv
hw/rtl/sliding_window_hit_counter.sv
verif/sliding_window_hit_counter_tb.sv
